[sv/bbservo_pkg.sv]
package bbservo_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam int TIMER_WIDTH_DEF = 16;

    localparam int VALUE_W = 32;
    localparam int TOL_W = 16;
    localparam int TICKS_W = 16;

    localparam int CMD_W = 3;
    typedef logic [CMD_W-1:0] cmd_t;

    localparam cmd_t CMD_EDGE = 3'd0;
    localparam cmd_t CMD_TICK = 3'd1;
    localparam cmd_t CMD_SET = 3'd2;
    localparam cmd_t CMD_CHANGE = 3'd3;
    localparam cmd_t CMD_HOME = 3'd4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 32;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_TOLERANCE = 3'd0;
    localparam cfg_index_t REG_MIN_TARGET = 3'd1;
    localparam cfg_index_t REG_PROBE = 3'd2;
    localparam cfg_index_t REG_SETTLE = 3'd3;
    localparam cfg_index_t REG_STALL = 3'd4;

    localparam logic [TOL_W-1:0] TOL_RESET = 16'd10;
    localparam logic [VALUE_W-1:0] MIN_TARGET_RESET = 32'd0;
    localparam logic [TICKS_W-1:0] PROBE_RESET = 16'd100;
    localparam logic [TICKS_W-1:0] SETTLE_RESET = 16'd500;
    localparam logic [TICKS_W-1:0] STALL_RESET = 16'd50;

endpackage

[sv/bbservo_if.sv]
interface bbservo_in_if;
    import bbservo_pkg::*;

    logic valid;
    logic ready;
    cmd_t cmd;
    logic encoder_b;
    logic signed [VALUE_W-1:0] target_value;

    modport source (output valid, cmd, encoder_b, target_value, input ready);
    modport sink (input valid, cmd, encoder_b, target_value, output ready);
endinterface

interface bbservo_out_if;
    import bbservo_pkg::*;

    logic valid;
    logic ready;
    logic drive_a;
    logic drive_b;
    logic [1:0] motion_state;
    logic is_homed;
    logic homing_busy;
    logic signed [VALUE_W-1:0] position_pulses;
    logic signed [VALUE_W-1:0] target_pulses;

    modport source (output valid, drive_a, drive_b, motion_state, is_homed, homing_busy,
                    position_pulses, target_pulses, input ready);
    modport sink (input valid, drive_a, drive_b, motion_state, is_homed, homing_busy,
                  position_pulses, target_pulses, output ready);
endinterface

[sv/bbservo_cfg.sv]
module bbservo_cfg #(
    parameter int COUNT_WIDTH = bbservo_pkg::COUNT_WIDTH_DEF,
    parameter int TIMER_WIDTH = bbservo_pkg::TIMER_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [bbservo_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [bbservo_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic [bbservo_pkg::TOL_W-1:0]        tolerance,
    output logic [COUNT_WIDTH-1:0]               min_target,
    output logic [TIMER_WIDTH-1:0]               probe_limit,
    output logic [TIMER_WIDTH-1:0]               settle_limit,
    output logic [TIMER_WIDTH-1:0]               stall_limit
);
    import bbservo_pkg::*;

    localparam int MW = (COUNT_WIDTH > VALUE_W ? COUNT_WIDTH : VALUE_W) + 1;
    localparam int LW = (TIMER_WIDTH > TICKS_W ? TIMER_WIDTH : TICKS_W);

    logic [TOL_W-1:0]   tol_reg;
    logic [VALUE_W-1:0] min_reg;
    logic [TICKS_W-1:0] probe_reg;
    logic [TICKS_W-1:0] settle_reg;
    logic [TICKS_W-1:0] stall_reg;

    logic signed [MW-1:0] min_ext;
    logic signed [MW-1:0] cmax_ext;
    logic signed [MW-1:0] cmin_ext;
    logic signed [MW-1:0] min_clamped;

    // zero acts as one tick; values past the timer range saturate
    function automatic logic [TIMER_WIDTH-1:0] tick_limit(input logic [TICKS_W-1:0] raw);
        logic [LW-1:0] raw_ext;
        logic [LW-1:0] tmax_ext;
        logic [LW-1:0] lim;
        raw_ext = LW'(raw);
        tmax_ext = LW'({TIMER_WIDTH{1'b1}});
        if (raw == '0)
            lim = LW'(1);
        else if (raw_ext > tmax_ext)
            lim = tmax_ext;
        else
            lim = raw_ext;
        return lim[TIMER_WIDTH-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg    <= TOL_RESET;
            min_reg    <= MIN_TARGET_RESET;
            probe_reg  <= PROBE_RESET;
            settle_reg <= SETTLE_RESET;
            stall_reg  <= STALL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TOLERANCE:  tol_reg    <= cfg_data[TOL_W-1:0];
                REG_MIN_TARGET: min_reg    <= cfg_data[VALUE_W-1:0];
                REG_PROBE:      probe_reg  <= cfg_data[TICKS_W-1:0];
                REG_SETTLE:     settle_reg <= cfg_data[TICKS_W-1:0];
                REG_STALL:      stall_reg  <= cfg_data[TICKS_W-1:0];
                default:        ;
            endcase
        end
    end

    // minimum target clamped into the signed count range
    assign min_ext  = {{(MW-VALUE_W){min_reg[VALUE_W-1]}}, min_reg};
    assign cmax_ext = {{(MW-COUNT_WIDTH+1){1'b0}}, {(COUNT_WIDTH-1){1'b1}}};
    assign cmin_ext = ~cmax_ext;

    always_comb
    begin
        if (min_ext > cmax_ext)
            min_clamped = cmax_ext;
        else if (min_ext < cmin_ext)
            min_clamped = cmin_ext;
        else
            min_clamped = min_ext;
    end

    assign tolerance    = tol_reg;
    assign min_target   = min_clamped[COUNT_WIDTH-1:0];
    assign probe_limit  = tick_limit(probe_reg);
    assign settle_limit = tick_limit(settle_reg);
    assign stall_limit  = tick_limit(stall_reg);

endmodule

[sv/encoder_bang_bang_position_servo.sv]
// Bang-bang position servo with stall homing. Every command (encoder edge, 1 ms tick,
// set or change target, start homing) is handled in the clock cycle in which it is
// transferred: that cycle updates the counter, target, drive and homing state and loads
// the result register, so a new command is taken every cycle while input ready is high
// and one result leaves per command, in order. The result register decouples the two
// channels: input ready is low only while a result is held and the sink is not ready.
// The pulse counter wraps at COUNT_WIDTH bits; the homing timer is TIMER_WIDTH bits and
// saturates. Target commands are ignored until homing has completed once and while homing runs.
module encoder_bang_bang_position_servo #(
    parameter int COUNT_WIDTH = bbservo_pkg::COUNT_WIDTH_DEF,
    parameter int TIMER_WIDTH = bbservo_pkg::TIMER_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bbservo_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bbservo_pkg::CFG_DATA_W-1:0]  cfg_data,
    bbservo_in_if.sink                          items,
    bbservo_out_if.source                       results
);
    import bbservo_pkg::*;

    localparam int EW = (COUNT_WIDTH > VALUE_W ? COUNT_WIDTH : VALUE_W) + 2;

    typedef enum logic [1:0] {DRV_BRAKE, DRV_FWD, DRV_BACK} drive_t;
    typedef enum logic [1:0] {PH_IDLE, PH_PROBE, PH_SETTLE, PH_BACK} phase_t;
    typedef enum logic [1:0] {MS_IN, MS_LOW, MS_HIGH} motion_t;

    logic [TOL_W-1:0]       tolerance;
    logic [COUNT_WIDTH-1:0] min_target;
    logic [TIMER_WIDTH-1:0] probe_limit;
    logic [TIMER_WIDTH-1:0] settle_limit;
    logic [TIMER_WIDTH-1:0] stall_limit;

    logic [COUNT_WIDTH-1:0] pulse_reg, pulse_next;
    logic [COUNT_WIDTH-1:0] target_reg, target_next;
    logic [COUNT_WIDTH-1:0] snap_reg, snap_next;
    logic [TIMER_WIDTH-1:0] timer_reg, timer_next;
    motion_t                motion_reg, motion_next;
    drive_t                 drive_reg, drive_next;
    phase_t                 phase_reg, phase_next;
    logic                   homed_reg, homed_next;
    logic                   swapped_reg, swapped_next;

    logic                   out_valid_reg;
    logic                   drive_a_reg, drive_b_reg;
    logic [1:0]             motion_out_reg;
    logic                   homed_out_reg, busy_out_reg;
    logic [VALUE_W-1:0]     position_out_reg, target_out_reg;

    logic                   accept;
    logic                   tgt_ok;
    logic                   is_edge, is_set, is_change;
    logic [COUNT_WIDTH-1:0] pulse_step;
    logic [TIMER_WIDTH-1:0] timer_inc;
    logic [TIMER_WIDTH-1:0] tick_lim;
    logic                   tick_done;
    logic [COUNT_WIDTH-1:0] probe_delta;
    logic                   stalled;
    logic                   finish;
    logic                   take;
    logic                   band;

    logic signed [EW-1:0]   tgt_ext, val_ext, lo_ext, cmax_ext, cmin_ext;
    logic signed [EW-1:0]   sum_ext, sat_ext, cand_ext, clamped_ext;
    logic [COUNT_WIDTH-1:0] take_tgt;
    logic [COUNT_WIDTH-1:0] err_a, err_b, err;
    logic signed [EW-1:0]   err_ext, tol_ext, ntol_ext;
    logic                   pin_a, pin_b;

    bbservo_cfg #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .tolerance    (tolerance),
        .min_target   (min_target),
        .probe_limit  (probe_limit),
        .settle_limit (settle_limit),
        .stall_limit  (stall_limit)
    );

    assign items.ready = !out_valid_reg || results.ready;
    assign accept = items.valid && items.ready;

    assign is_edge   = (items.cmd == CMD_EDGE);
    assign is_set    = (items.cmd == CMD_SET);
    assign is_change = (items.cmd == CMD_CHANGE);
    assign tgt_ok    = homed_reg && (phase_reg == PH_IDLE);

    assign pulse_step = items.encoder_b ? pulse_reg + 1'b1 : pulse_reg - 1'b1;

    // homing timer
    assign timer_inc = (timer_reg == {TIMER_WIDTH{1'b1}}) ? timer_reg : timer_reg + 1'b1;

    always_comb
    begin
        case (phase_reg)
            PH_PROBE:  tick_lim = probe_limit;
            PH_SETTLE: tick_lim = settle_limit;
            default:   tick_lim = stall_limit;
        endcase
    end

    assign tick_done   = (timer_inc >= tick_lim);
    assign probe_delta = pulse_reg - snap_reg;
    assign stalled     = (pulse_reg == snap_reg);
    assign finish      = (items.cmd == CMD_TICK) && (phase_reg == PH_BACK) && tick_done && stalled;
    assign take        = ((is_set || is_change) && tgt_ok) || finish;

    // new target: the set value, a saturating nudge, or the minimum on homing; then clamp at the minimum
    assign tgt_ext  = {{(EW-COUNT_WIDTH){target_reg[COUNT_WIDTH-1]}}, target_reg};
    assign val_ext  = {{(EW-VALUE_W){items.target_value[VALUE_W-1]}}, items.target_value};
    assign lo_ext   = {{(EW-COUNT_WIDTH){min_target[COUNT_WIDTH-1]}}, min_target};
    assign cmax_ext = {{(EW-COUNT_WIDTH+1){1'b0}}, {(COUNT_WIDTH-1){1'b1}}};
    assign cmin_ext = ~cmax_ext;
    assign sum_ext  = tgt_ext + val_ext;

    always_comb
    begin
        if (sum_ext > cmax_ext)
            sat_ext = cmax_ext;
        else if (sum_ext < cmin_ext)
            sat_ext = cmin_ext;
        else
            sat_ext = sum_ext;

        if (finish)
            cand_ext = lo_ext;
        else if (is_set)
            cand_ext = val_ext;
        else
            cand_ext = sat_ext;

        clamped_ext = (cand_ext < lo_ext) ? lo_ext : cand_ext;
    end

    assign take_tgt = clamped_ext[COUNT_WIDTH-1:0];

    // one error for whichever path runs this cycle
    assign err_a = is_edge ? pulse_step : (finish ? '0 : pulse_reg);
    assign err_b = take ? take_tgt : target_reg;
    assign err   = err_a - err_b;

    assign err_ext  = {{(EW-COUNT_WIDTH){err[COUNT_WIDTH-1]}}, err};
    assign tol_ext  = {{(EW-TOL_W){1'b0}}, tolerance};
    assign ntol_ext = -tol_ext;

    assign band = (is_edge || (items.cmd == CMD_TICK)) && (phase_reg == PH_IDLE);

    always_comb
    begin
        pulse_next   = pulse_reg;
        target_next  = target_reg;
        snap_next    = snap_reg;
        timer_next   = timer_reg;
        motion_next  = motion_reg;
        drive_next   = drive_reg;
        phase_next   = phase_reg;
        homed_next   = homed_reg;
        swapped_next = swapped_reg;

        if (accept)
        begin
            case (items.cmd)
                CMD_EDGE:
                begin
                    pulse_next = pulse_step;
                end
                CMD_TICK:
                begin
                    case (phase_reg)
                        PH_PROBE:
                        begin
                            timer_next = timer_inc;
                            if (tick_done)
                            begin
                                drive_next = DRV_BRAKE;
                                phase_next = PH_SETTLE;
                                timer_next = '0;
                            end
                        end
                        PH_SETTLE:
                        begin
                            timer_next = timer_inc;
                            if (tick_done)
                            begin
                                if (probe_delta[COUNT_WIDTH-1])
                                    swapped_next = !swapped_reg;
                                drive_next = DRV_BACK;
                                snap_next  = pulse_reg;
                                phase_next = PH_BACK;
                                timer_next = '0;
                            end
                        end
                        PH_BACK:
                        begin
                            timer_next = timer_inc;
                            if (tick_done)
                            begin
                                timer_next = '0;
                                if (stalled)
                                begin
                                    drive_next = DRV_BRAKE;
                                    pulse_next = '0;
                                    homed_next = 1'b1;
                                    phase_next = PH_IDLE;
                                end
                                else
                                    snap_next = pulse_reg;
                            end
                        end
                        default: ;
                    endcase
                end
                CMD_HOME:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        snap_next  = pulse_reg;
                        drive_next = DRV_FWD;
                        timer_next = '0;
                        phase_next = PH_PROBE;
                    end
                end
                default: ;
            endcase

            if (take)
            begin
                target_next = take_tgt;
                if (err_ext > tol_ext)
                begin
                    motion_next = MS_HIGH;
                    drive_next  = DRV_BACK;
                end
                else if (err_ext < ntol_ext)
                begin
                    motion_next = MS_LOW;
                    drive_next  = DRV_FWD;
                end
                else
                begin
                    motion_next = MS_IN;
                    drive_next  = DRV_BRAKE;
                end
            end
            else if (band)
            begin
                if ((motion_reg == MS_LOW && err_ext > ntol_ext) ||
                    (motion_reg == MS_HIGH && err_ext < tol_ext))
                    motion_next = MS_IN;
                if (motion_next == MS_IN)
                    drive_next = DRV_BRAKE;
            end
        end
    end

    always_comb
    begin
        case (drive_next)
            DRV_FWD:
            begin
                pin_a = 1'b1;
                pin_b = 1'b0;
            end
            DRV_BACK:
            begin
                pin_a = 1'b0;
                pin_b = 1'b1;
            end
            default:
            begin
                pin_a = 1'b1;
                pin_b = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_reg     <= '0;
            target_reg    <= '0;
            snap_reg      <= '0;
            timer_reg     <= '0;
            motion_reg    <= MS_IN;
            drive_reg     <= DRV_BRAKE;
            phase_reg     <= PH_IDLE;
            homed_reg     <= 1'b0;
            swapped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pulse_reg   <= pulse_next;
            target_reg  <= target_next;
            snap_reg    <= snap_next;
            timer_reg   <= timer_next;
            motion_reg  <= motion_next;
            drive_reg   <= drive_next;
            phase_reg   <= phase_next;
            homed_reg   <= homed_next;
            swapped_reg <= swapped_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            drive_a_reg      <= swapped_next ? pin_b : pin_a;
            drive_b_reg      <= swapped_next ? pin_a : pin_b;
            motion_out_reg   <= motion_next;
            homed_out_reg    <= homed_next;
            busy_out_reg     <= (phase_next != PH_IDLE);
            position_out_reg <= VALUE_W'(pulse_next);
            target_out_reg   <= VALUE_W'(target_next);
        end
    end

    assign results.valid           = out_valid_reg;
    assign results.drive_a         = drive_a_reg;
    assign results.drive_b         = drive_b_reg;
    assign results.motion_state    = motion_out_reg;
    assign results.is_homed        = homed_out_reg;
    assign results.homing_busy     = busy_out_reg;
    assign results.position_pulses = position_out_reg;
    assign results.target_pulses   = target_out_reg;

    a_homed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        homed_reg |=> homed_reg)
        else $error("homed flag dropped");

    a_target_locked: assert property (@(posedge clk) disable iff (!rst_n)
        !homed_reg |=> (homed_reg || $stable(target_reg)))
        else $error("target moved before homing");

    a_motion_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_IDLE) |=> (phase_reg == PH_IDLE || $stable(motion_reg)))
        else $error("motion state changed during homing");

    a_brake_in_band: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE && motion_reg == MS_IN) |-> (drive_reg == DRV_BRAKE))
        else $error("motor driven while in band");

    a_timer_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (timer_reg == '0))
        else $error("homing timer running while idle");

endmodule
